// File: rtl/core/brb_pkg.sv
`default_nettype none

package brb_pkg;

    // Fixed field widths
    localparam int OP_W    = 3;
    localparam int SIZE_W  = 11;
    localparam int POS_W   = 10;
    localparam int DATA_W  = 8;
    localparam int ST_W    = 3;

    // Storage defaults
    localparam int DEPTH_DEF  = 1024;
    localparam int SIZE_RESET = 1024;

    // Operation codes on the input channel
    localparam logic [OP_W-1:0] OPC_SEND   = 3'd0;
    localparam logic [OP_W-1:0] OPC_RECV   = 3'd1;
    localparam logic [OP_W-1:0] OPC_READ   = 3'd2;
    localparam logic [OP_W-1:0] OPC_RETURN = 3'd3;
    localparam logic [OP_W-1:0] OPC_INFO   = 3'd4;

    // Decoded operation
    typedef enum logic [2:0] {
        OP_SEND,
        OP_RECV,
        OP_READ,
        OP_RETURN,
        OP_INFO,
        OP_NOP
    } brb_op_t;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_PENDING  = 3'd3,
        ST_MISMATCH = 3'd4,
        ST_ZERO_MAX = 3'd5
    } brb_status_t;

    // Classified item as it travels from front to back
    typedef struct packed {
        brb_op_t             op;
        logic                len_zero;
        logic [SIZE_W-1:0]   len;
        logic [DATA_W-1:0]   data;
        logic                last;
        logic [POS_W-1:0]    pos;
    } brb_item_t;

endpackage

`default_nettype wire

// File: rtl/core/brb_front.sv
`default_nettype none

module brb_front
    import brb_pkg::*;
(
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [SIZE_W-1:0] item_length,
    input  wire logic [DATA_W-1:0] data_byte,
    input  wire logic              last_byte,
    input  wire logic [POS_W-1:0]  position,
    output brb_item_t              item
);

    brb_op_t op_dec;

    // Decode the operation code; unused codes become a no-op
    always_comb
    begin
        case (op)
            OPC_SEND:   op_dec = OP_SEND;
            OPC_RECV:   op_dec = OP_RECV;
            OPC_READ:   op_dec = OP_READ;
            OPC_RETURN: op_dec = OP_RETURN;
            OPC_INFO:   op_dec = OP_INFO;
            default:    op_dec = OP_NOP;
        endcase
    end

    // Pack the classified item
    always_comb
    begin
        item.op       = op_dec;
        item.len_zero = (item_length == '0);
        item.len      = item_length;
        item.data     = data_byte;
        item.last     = last_byte;
        item.pos      = position;
    end

endmodule

`default_nettype wire

// File: rtl/core/brb_queue.sv
`default_nettype none

module brb_queue
    import brb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire brb_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output logic           not_empty,
    output brb_item_t      head
);

    // Two-entry queue between front and back
    brb_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/brb_back.sv
`default_nettype none

module brb_back
    import brb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_wdata,
    input  wire logic              q_valid,
    input  wire brb_item_t         q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ST_W-1:0]        status,
    output logic [POS_W-1:0]       region_start,
    output logic [SIZE_W-1:0]      region_length,
    output logic [DATA_W-1:0]      read_data,
    output logic [SIZE_W-1:0]      free_count,
    output logic [SIZE_W-1:0]      used_bytes
);

    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DEPTH_CAP = (DEPTH > 2047) ? 2047 : DEPTH;
    localparam int RST_SIZE  = (DEPTH < SIZE_RESET) ? DEPTH : SIZE_RESET;
    localparam logic [SIZE_W-1:0] SIZE_CAP  = SIZE_W'(DEPTH_CAP);
    localparam logic [SIZE_W-1:0] SIZE_INIT = SIZE_W'(RST_SIZE);

    // Buffer state
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] wp_reg, wp_next;
    logic [SIZE_W-1:0] rp_reg, rp_next;
    logic [SIZE_W-1:0] fill_reg, fill_next;
    logic [SIZE_W-1:0] pend_reg, pend_next;
    logic              act_reg, act_next;
    logic              rej_reg, rej_next;
    logic [SIZE_W-1:0] wrt_reg, wrt_next;
    logic [SIZE_W-1:0] slen_reg, slen_next;

    // Output stage
    logic              out_valid_reg, out_valid_next;
    brb_status_t       st_reg, st_next;
    logic [POS_W-1:0]  rstart_reg, rstart_next;
    logic [SIZE_W-1:0] rlen_reg, rlen_next;
    logic              rsel_reg, rsel_next;
    logic [SIZE_W-1:0] free_reg, free_next;
    logic [SIZE_W-1:0] used_reg, used_next;

    // Storage
    logic [DATA_W-1:0] storage [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic              mem_re;

    // Execute strobe
    logic              fire;

    // Send datapath
    logic [SIZE_W-1:0] space;
    logic              fits;
    logic [SIZE_W-1:0] cur_wrt;
    logic              do_store;
    logic [SIZE_W:0]   st_sum;
    logic [SIZE_W-1:0] st_addr;
    logic [SIZE_W-1:0] wrt_new;
    logic              rej_new;
    logic [SIZE_W:0]   cm_sum;
    logic [SIZE_W:0]   rt_sum;
    logic [SIZE_W-1:0] run;
    logic [SIZE_W-1:0] grant;
    logic [SIZE_W-1:0] cfg_size;

    assign fire  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = fire;

    // Saturate the configured size into 1..DEPTH, at most 2047
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_size = SIZE_W'(1);
        end
        else if (cfg_wdata > SIZE_CAP)
        begin
            cfg_size = SIZE_CAP;
        end
        else
        begin
            cfg_size = cfg_wdata;
        end
    end

    // Shared arithmetic for send, receive and return
    always_comb
    begin
        space    = size_reg - fill_reg;
        fits     = (q_item.len <= space);
        cur_wrt  = act_reg ? wrt_reg : '0;
        do_store = (!act_reg && !q_item.len_zero && fits)
                   || (act_reg && !rej_reg && (wrt_reg < slen_reg));
        st_sum   = {1'b0, wp_reg} + {1'b0, cur_wrt};
        st_addr  = (st_sum >= {1'b0, size_reg}) ? SIZE_W'(st_sum - {1'b0, size_reg})
                                                : SIZE_W'(st_sum);
        wrt_new  = cur_wrt + SIZE_W'(do_store);
        rej_new  = act_reg ? rej_reg : !fits;
        cm_sum   = {1'b0, wp_reg} + {1'b0, wrt_new};
        rt_sum   = {1'b0, rp_reg} + {1'b0, pend_reg};
        run      = size_reg - rp_reg;
        grant    = fill_reg;
        if (grant > run)
        begin
            grant = run;
        end
        if (grant > q_item.len)
        begin
            grant = q_item.len;
        end
    end

    // Operation execution
    always_comb
    begin
        size_next   = size_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        fill_next   = fill_reg;
        pend_next   = pend_reg;
        act_next    = act_reg;
        rej_next    = rej_reg;
        wrt_next    = wrt_reg;
        slen_next   = slen_reg;
        st_next     = st_reg;
        rstart_next = rstart_reg;
        rlen_next   = rlen_reg;
        rsel_next   = rsel_reg;
        free_next   = free_reg;
        used_next   = used_reg;
        mem_we      = 1'b0;
        mem_waddr   = AW'(st_addr);
        mem_re      = 1'b0;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (cfg_we)
        begin
            size_next = cfg_size;
            wp_next   = '0;
            rp_next   = '0;
            fill_next = '0;
            pend_next = '0;
            act_next  = 1'b0;
            rej_next  = 1'b0;
            wrt_next  = '0;
            slen_next = '0;
        end
        else if (fire)
        begin
            out_valid_next = 1'b1;
            st_next        = ST_OK;
            rstart_next    = '0;
            rlen_next      = '0;
            rsel_next      = 1'b0;
            free_next      = '0;
            used_next      = '0;
            case (q_item.op)
                OP_SEND:
                begin
                    // Zero-length send outside a send: nothing is stored and no send opens
                    if (act_reg || !q_item.len_zero)
                    begin
                        mem_we = do_store;
                        if ((!act_reg && !fits) || (act_reg && !do_store))
                        begin
                            st_next = ST_NO_SPACE;
                        end
                        if (!act_reg)
                        begin
                            slen_next = fits ? q_item.len : '0;
                        end
                        act_next = 1'b1;
                        rej_next = rej_new;
                        wrt_next = wrt_new;
                        if (q_item.last)
                        begin
                            if (!rej_new)
                            begin
                                wp_next   = (cm_sum >= {1'b0, size_reg})
                                            ? SIZE_W'(cm_sum - {1'b0, size_reg})
                                            : SIZE_W'(cm_sum);
                                fill_next = fill_reg + wrt_new;
                            end
                            act_next  = 1'b0;
                            rej_next  = 1'b0;
                            wrt_next  = '0;
                            slen_next = '0;
                        end
                    end
                end
                OP_RECV:
                begin
                    if (q_item.len_zero)
                    begin
                        st_next = ST_ZERO_MAX;
                    end
                    else if (pend_reg != '0)
                    begin
                        st_next = ST_PENDING;
                    end
                    else if (fill_reg == '0)
                    begin
                        st_next = ST_EMPTY;
                    end
                    else
                    begin
                        pend_next   = grant;
                        rstart_next = POS_W'(rp_reg);
                        rlen_next   = grant;
                    end
                end
                OP_READ:
                begin
                    mem_re    = 1'b1;
                    rsel_next = (32'(q_item.pos) < DEPTH);
                end
                OP_RETURN:
                begin
                    if ((pend_reg != '0) && ({1'b0, q_item.pos} == rp_reg))
                    begin
                        rp_next   = (rt_sum >= {1'b0, size_reg})
                                    ? SIZE_W'(rt_sum - {1'b0, size_reg})
                                    : SIZE_W'(rt_sum);
                        fill_next = fill_reg - pend_reg;
                        pend_next = '0;
                    end
                    else
                    begin
                        st_next = ST_MISMATCH;
                    end
                end
                OP_INFO:
                begin
                    free_next = space;
                    used_next = fill_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control and buffer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_INIT;
            wp_reg        <= '0;
            rp_reg        <= '0;
            fill_reg      <= '0;
            pend_reg      <= '0;
            act_reg       <= 1'b0;
            rej_reg       <= 1'b0;
            wrt_reg       <= '0;
            slen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            act_reg       <= act_next;
            rej_reg       <= rej_next;
            wrt_reg       <= wrt_next;
            slen_reg      <= slen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        st_reg     <= st_next;
        rstart_reg <= rstart_next;
        rlen_reg   <= rlen_next;
        rsel_reg   <= rsel_next;
        free_reg   <= free_next;
        used_reg   <= used_next;
    end

    // Byte storage, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            storage[mem_waddr] <= q_item.data;
        end
        if (mem_re)
        begin
            rdata_reg <= storage[AW'(q_item.pos)];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = st_reg;
    assign region_start  = rstart_reg;
    assign region_length = rlen_reg;
    assign read_data     = rsel_reg ? rdata_reg : '0;
    assign free_count    = free_reg;
    assign used_bytes    = used_reg;

endmodule

`default_nettype wire

// File: rtl/core/byte_ring_buffer_zero_copy_unit.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    op, item_length, data_byte, last_byte, position
// output    out_valid / out_ready  status, region_start, region_length, read_data,
//                                  free_count, used_bytes
// config    cfg_we                 cfg_wdata (buffer size)
//
// An item is written into the queue at its accepting edge and executed by the back
// end in the next cycle unless the output stalls; its result is then registered in
// the output stage. With no stalls one item per cycle is sustained.
// The byte memory has one write and one registered read port.
// Reset sets the buffer size to the lesser of 1024 and DEPTH and empties it.
// A stalled output holds the back end; the two-entry queue takes up to two more
// items before in_ready drops.
`default_nettype none

module byte_ring_buffer_zero_copy_unit
    import brb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [SIZE_W-1:0] item_length,
    input  wire logic [DATA_W-1:0] data_byte,
    input  wire logic              last_byte,
    input  wire logic [POS_W-1:0]  position,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ST_W-1:0]        status,
    output logic [POS_W-1:0]       region_start,
    output logic [SIZE_W-1:0]      region_length,
    output logic [DATA_W-1:0]      read_data,
    output logic [SIZE_W-1:0]      free_count,
    output logic [SIZE_W-1:0]      used_bytes
);

    brb_item_t in_item;
    brb_item_t q_item;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;

    assign in_ready = !q_full;

    // Front: classify incoming items
    brb_front u_front (
        .op          (op),
        .item_length (item_length),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .position    (position),
        .item        (in_item)
    );

    // Queue between front and back
    brb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_item)
    );

    // Back: execute against buffer state
    brb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .region_start  (region_start),
        .region_length (region_length),
        .read_data     (read_data),
        .free_count    (free_count),
        .used_bytes    (used_bytes)
    );

endmodule

`default_nettype wire

// File: test/tb_byte_ring_buffer_zero_copy_unit.sv
`default_nettype none

module tb_byte_ring_buffer_zero_copy_unit;
    import brb_pkg::*;

    localparam int RING_DEPTH     = DEPTH_DEF;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SIZE_MAX_CODE  = (1 << SIZE_W) - 1;
    localparam int OP_MAX_CODE    = (1 << OP_W) - 1;

    // One reply of the ring as the block should present it
    typedef struct {
        brb_status_t        st;
        logic [POS_W-1:0]   rstart;
        logic [SIZE_W-1:0]  rlen;
        logic [DATA_W-1:0]  rdata;
        logic [SIZE_W-1:0]  nfree;
        logic [SIZE_W-1:0]  nused;
    } ring_reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   op = '0;
    logic [SIZE_W-1:0] item_length = '0;
    logic [DATA_W-1:0] data_byte = '0;
    logic              last_byte = 1'b0;
    logic [POS_W-1:0]  position = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ST_W-1:0]   status;
    logic [POS_W-1:0]  region_start;
    logic [SIZE_W-1:0] region_length;
    logic [DATA_W-1:0] read_data;
    logic [SIZE_W-1:0] free_count;
    logic [SIZE_W-1:0] used_bytes;

    // Shadow ring state
    logic [DATA_W-1:0] rb_mem [RING_DEPTH];
    bit                rb_valid_byte [RING_DEPTH];
    int unsigned       rb_written_pos [$];
    int unsigned       rb_size_reg;
    int unsigned       rb_wr;
    int unsigned       rb_rd;
    int unsigned       rb_fill;
    int unsigned       rb_claim;
    bit                rb_snd_on;
    bit                rb_snd_drop;
    int unsigned       rb_snd_cnt;
    int unsigned       rb_snd_len;

    ring_reply_t       ring_replies_q [$];
    int unsigned       item_count;
    int unsigned       mismatch_count;
    int unsigned       idle_pct;
    int unsigned       quiet_cycles;
    bit                rx_hold_req;
    int unsigned       rx_hold_left;

    byte_ring_buffer_zero_copy_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .item_length   (item_length),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .position      (position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .region_start  (region_start),
        .region_length (region_length),
        .read_data     (read_data),
        .free_count    (free_count),
        .used_bytes    (used_bytes)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Size in use, saturated into 1..depth
    function automatic int unsigned ring_size();
        if (rb_size_reg == 0)
            return 1;
        if (rb_size_reg > RING_DEPTH)
            return RING_DEPTH;
        return rb_size_reg;
    endfunction

    function automatic int unsigned ring_wrap(int unsigned a, int unsigned b, int unsigned size);
        int unsigned s;
        s = a + b;
        while (s >= size)
            s -= size;
        return s;
    endfunction

    // Empties the ring; stored bytes survive
    function automatic void ring_clear();
        rb_wr       = 0;
        rb_rd       = 0;
        rb_fill     = 0;
        rb_claim    = 0;
        rb_snd_on   = 1'b0;
        rb_snd_drop = 1'b0;
        rb_snd_cnt  = 0;
        rb_snd_len  = 0;
    endfunction

    function automatic void ring_store(logic [DATA_W-1:0] value, int unsigned size);
        int unsigned addr;
        addr = ring_wrap(rb_wr, rb_snd_cnt, size);
        rb_mem[addr[POS_W-1:0]] = value;
        if (!rb_valid_byte[addr[POS_W-1:0]])
        begin
            rb_valid_byte[addr[POS_W-1:0]] = 1'b1;
            rb_written_pos.push_back(addr);
        end
        rb_snd_cnt++;
    endfunction

    // Applies one accepted item to the shadow ring and queues its reply
    function automatic void ring_apply(logic [OP_W-1:0] f_op, logic [SIZE_W-1:0] f_len,
                                       logic [DATA_W-1:0] f_data, logic f_last,
                                       logic [POS_W-1:0] f_pos);
        ring_reply_t r;
        int unsigned size;
        int unsigned len;
        int unsigned n;
        bit          ends_send;
        r.st     = ST_OK;
        r.rstart = '0;
        r.rlen   = '0;
        r.rdata  = '0;
        r.nfree  = '0;
        r.nused  = '0;
        size     = ring_size();
        len      = 32'(f_len);
        case (f_op)
            OPC_SEND:
            begin
                ends_send = 1'b1;
                if (!rb_snd_on)
                begin
                    // zero-length send: nothing stored, no send opened
                    if (len == 0)
                        ends_send = 1'b0;
                    else
                    begin
                        rb_snd_cnt = 0;
                        if (len > size - rb_fill)
                        begin
                            rb_snd_drop = 1'b1;
                            rb_snd_len  = 0;
                            r.st        = ST_NO_SPACE;
                        end
                        else
                        begin
                            rb_snd_drop = 1'b0;
                            rb_snd_len  = len;
                            ring_store(f_data, size);
                        end
                        rb_snd_on = 1'b1;
                    end
                end
                else if (rb_snd_drop)
                    r.st = ST_NO_SPACE;
                else if (rb_snd_cnt < rb_snd_len)
                    ring_store(f_data, size);
                else
                    r.st = ST_NO_SPACE;
                // commit on the last flag
                if (ends_send && f_last)
                begin
                    if (!rb_snd_drop)
                    begin
                        rb_wr   = ring_wrap(rb_wr, rb_snd_cnt, size);
                        rb_fill += rb_snd_cnt;
                    end
                    rb_snd_on   = 1'b0;
                    rb_snd_drop = 1'b0;
                    rb_snd_cnt  = 0;
                    rb_snd_len  = 0;
                end
            end
            OPC_RECV:
            begin
                if (len == 0)
                    r.st = ST_ZERO_MAX;
                else if (rb_claim != 0)
                    r.st = ST_PENDING;
                else if (rb_fill == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    n = rb_fill;
                    if (n > size - rb_rd)
                        n = size - rb_rd;
                    if (n > len)
                        n = len;
                    rb_claim = n;
                    r.rstart = rb_rd[POS_W-1:0];
                    r.rlen   = n[SIZE_W-1:0];
                end
            end
            OPC_READ:
                r.rdata = rb_mem[f_pos];
            OPC_RETURN:
            begin
                if (rb_claim != 0 && 32'(f_pos) == rb_rd)
                begin
                    rb_rd    = ring_wrap(rb_rd, rb_claim, size);
                    rb_fill -= rb_claim;
                    rb_claim = 0;
                end
                else
                    r.st = ST_MISMATCH;
            end
            OPC_INFO:
            begin
                r.nfree = SIZE_W'(size - rb_fill);
                r.nused = SIZE_W'(rb_fill);
            end
            default:
                ;
        endcase
        ring_replies_q.push_back(r);
    endfunction

    // Offers one item and waits for it to be taken
    task automatic issue_item(input logic [OP_W-1:0] i_op, input int unsigned i_len,
                              input logic [DATA_W-1:0] i_data, input logic i_last,
                              input logic [POS_W-1:0] i_pos);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= i_op;
        item_length <= i_len[SIZE_W-1:0];
        data_byte   <= i_data;
        last_byte   <= i_last;
        position    <= i_pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ring_apply(i_op, i_len[SIZE_W-1:0], i_data, i_last, i_pos);
        if (i_op <= OPC_INFO)
            item_count++;
    endtask

    // Stops offering and waits for every reply plus the pipeline tail
    task automatic drain_ring();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ring_replies_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input int unsigned value);
        drain_ring();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[SIZE_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        rb_size_reg = value & SIZE_MAX_CODE;
        ring_clear();
        @(posedge clk);
    endtask

    // Every op at least once, zero-length sends and unknown codes
    task automatic test_basic_ops();
        issue_item(OPC_INFO, 0, 8'h00, 1'b0, '0);
        issue_item(OPC_RECV, 0, 8'h00, 1'b0, '0);
        issue_item(OPC_RECV, 5, 8'h00, 1'b0, '0);
        issue_item(OPC_RETURN, 0, 8'h00, 1'b0, '0);
        issue_item(OPC_SEND, 0, 8'h11, 1'b0, '0);
        issue_item(OPC_SEND, 0, 8'h22, 1'b1, '0);
        issue_item(OPC_SEND, 3, 8'h00, 1'b0, '0);
        issue_item(OPC_SEND, 3, 8'hFF, 1'b0, '0);
        issue_item(OPC_SEND, 3, 8'hA5, 1'b1, '1);
        issue_item(OPC_READ, 0, 8'h00, 1'b0, 10'd1);
        issue_item(OPC_READ, 0, 8'h00, 1'b0, 10'd2);
        for (int k = int'(OPC_INFO) + 1; k <= OP_MAX_CODE; k++)
            issue_item(k[OP_W-1:0], SIZE_MAX_CODE, 8'hFF, 1'b1, '1);
    endtask

    // Rejected, surplus and short sends
    task automatic test_send_cases();
        issue_item(OPC_SEND, RING_DEPTH, 8'h5A, 1'b0, '0);
        issue_item(OPC_SEND, RING_DEPTH, 8'hC3, 1'b1, '0);
        issue_item(OPC_SEND, 1, 8'h3C, 1'b0, '0);
        issue_item(OPC_SEND, 1, 8'h99, 1'b1, '0);
        issue_item(OPC_SEND, 4, 8'h01, 1'b0, '0);
        issue_item(OPC_SEND, 4, 8'h80, 1'b1, '0);
        issue_item(OPC_INFO, 0, 8'h00, 1'b0, '0);
    endtask

    // Claim grant, pending claim, order of receive checks, return matching
    task automatic test_claims();
        issue_item(OPC_RECV, RING_DEPTH, 8'h00, 1'b0, '0);
        issue_item(OPC_RECV, 1, 8'h00, 1'b0, '0);
        issue_item(OPC_RECV, 0, 8'h00, 1'b0, '0);
        issue_item(OPC_RETURN, 0, 8'h00, 1'b0, 10'd5);
        issue_item(OPC_RETURN, 0, 8'h00, 1'b0, rb_rd[POS_W-1:0]);
        issue_item(OPC_RETURN, 0, 8'h00, 1'b0, rb_rd[POS_W-1:0]);
        issue_item(OPC_INFO, 0, 8'h00, 1'b0, '0);
    endtask

    // Size saturation, wrap and run clamp at the buffer end, clearing a send
    task automatic test_size_extremes();
        write_size(0);
        issue_item(OPC_SEND, 1, 8'h44, 1'b1, '0);
        issue_item(OPC_SEND, 1, 8'h45, 1'b1, '0);
        issue_item(OPC_INFO, 0, 8'h00, 1'b0, '0);
        issue_item(OPC_RECV, 4, 8'h00, 1'b0, '0);
        issue_item(OPC_RETURN, 0, 8'h00, 1'b0, '0);
        write_size(2);
        issue_item(OPC_SEND, 2, 8'h61, 1'b0, '0);
        issue_item(OPC_SEND, 2, 8'h62, 1'b1, '0);
        issue_item(OPC_RECV, 1, 8'h00, 1'b0, '0);
        issue_item(OPC_RETURN, 0, 8'h00, 1'b0, 10'd0);
        issue_item(OPC_SEND, 1, 8'h63, 1'b1, '0);
        issue_item(OPC_RECV, 5, 8'h00, 1'b0, '0);
        issue_item(OPC_RETURN, 0, 8'h00, 1'b0, 10'd1);
        issue_item(OPC_RECV, 5, 8'h00, 1'b0, '0);
        issue_item(OPC_RETURN, 0, 8'h00, 1'b0, 10'd0);
        write_size(SIZE_MAX_CODE);
        issue_item(OPC_INFO, 0, 8'h00, 1'b0, '0);
        // send left open across a size write
        issue_item(OPC_SEND, 5, 8'h77, 1'b0, '0);
        write_size(SIZE_RESET);
        issue_item(OPC_INFO, 0, 8'h00, 1'b0, '0);
        issue_item(OPC_SEND, 1, 8'h78, 1'b1, '0);
        issue_item(OPC_READ, 0, 8'h00, 1'b0, 10'd0);
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        idle_pct    = 6;
        rx_hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
            issue_item(OPC_SEND, 1, DATA_W'($urandom), 1'b1, POS_W'($urandom));
        issue_item(OPC_INFO, 0, 8'h00, 1'b0, '0);
        drain_ring();
    endtask

    // Mostly well-formed sends and claim/return pairs, with broken sequences and noise
    task automatic test_random_round(input int unsigned size_val, input int unsigned n,
                                     input int unsigned idle);
        int unsigned goal;
        int unsigned size;
        int unsigned room;
        int unsigned len;
        int unsigned nbytes;
        int unsigned pick;
        int unsigned k;
        write_size(size_val);
        idle_pct = idle;
        goal     = item_count + n;
        while (item_count < goal)
        begin
            size = ring_size();
            room = size - rb_fill;
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                k = $urandom_range(0, 19);
                if (k == 0)
                    len = 0;
                else if (k == 1)
                    len = $urandom_range(size, SIZE_MAX_CODE);
                else if (k == 2 && room != 0 && room <= 48)
                    len = room;
                else
                    len = $urandom_range(1, (size < 12) ? size : 12);
                k = $urandom_range(0, 9);
                if (len == 0 || len > 48)
                    nbytes = $urandom_range(1, 3);
                else if (k == 0)
                    nbytes = $urandom_range(1, len);
                else if (k == 1)
                    nbytes = len + $urandom_range(1, 3);
                else
                    nbytes = len;
                for (int i = 0; i < nbytes; i++)
                    issue_item(OPC_SEND, len, DATA_W'($urandom), i == nbytes - 1,
                               POS_W'($urandom));
            end
            else if (pick < 70)
            begin
                k = $urandom_range(0, 9);
                if (k == 0)
                    len = 0;
                else if (k == 1)
                    len = $urandom_range(RING_DEPTH, SIZE_MAX_CODE);
                else
                    len = $urandom_range(1, size);
                issue_item(OPC_RECV, len, DATA_W'($urandom), 1'($urandom), POS_W'($urandom));
                if (rb_claim != 0 && $urandom_range(0, 9) < 7)
                    issue_item(OPC_RETURN, $urandom, DATA_W'($urandom), 1'($urandom),
                               rb_rd[POS_W-1:0]);
            end
            else if (pick < 80)
                issue_item(OPC_RETURN, $urandom, DATA_W'($urandom), 1'($urandom),
                           $urandom_range(0, 1) ? rb_rd[POS_W-1:0] : POS_W'($urandom));
            else if (pick < 90 && rb_written_pos.size() != 0)
                issue_item(OPC_READ, $urandom, DATA_W'($urandom), 1'($urandom),
                           POS_W'(rb_written_pos[$urandom_range(0, rb_written_pos.size() - 1)]));
            else if (pick < 96)
                issue_item(OPC_INFO, $urandom, DATA_W'($urandom), 1'($urandom),
                           POS_W'($urandom));
            else if (pick < 98)
                issue_item(OP_W'($urandom_range(int'(OPC_INFO) + 1, OP_MAX_CODE)),
                           $urandom, DATA_W'($urandom), 1'($urandom), POS_W'($urandom));
            else
                // stray byte that may land inside or open a send
                issue_item(OPC_SEND, $urandom_range(0, SIZE_MAX_CODE), DATA_W'($urandom),
                           1'($urandom), POS_W'($urandom));
        end
    endtask

    // Receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (rx_hold_req)
        begin
            rx_hold_req  = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    task automatic check_field(input string what, input logic [SIZE_W-1:0] want,
                               input logic [SIZE_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Reply checker
    always @(posedge clk)
    begin
        ring_reply_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (ring_replies_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: reply mismatch, expected none, got status %0d", $time, status);
            end
            else
            begin
                w = ring_replies_q.pop_front();
                check_field("status", SIZE_W'(w.st), SIZE_W'(status));
                check_field("region_start", SIZE_W'(w.rstart), SIZE_W'(region_start));
                check_field("region_length", w.rlen, region_length);
                check_field("read_data", SIZE_W'(w.rdata), SIZE_W'(read_data));
                check_field("free_count", w.nfree, free_count);
                check_field("used_bytes", w.nused, used_bytes);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            rb_mem[i]        = '0;
            rb_valid_byte[i] = 1'b0;
        end
        rb_size_reg    = SIZE_RESET;
        ring_clear();
        item_count     = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        rx_hold_req    = 1'b0;
        rx_hold_left   = 0;
        idle_pct       = 6;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_send_cases();
        test_claims();
        test_size_extremes();
        test_backpressure();
        test_random_round(SIZE_RESET, 180, 0);
        test_random_round($urandom_range(3, 64), 130, 6);
        test_random_round(1, 50, 6);
        test_random_round(SIZE_MAX_CODE, 170, 6);
        drain_ring();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
